// File: rtl/core/ple_pkg.sv
// Shared types and codes for the positional list engine.
`default_nettype none
package ple_pkg;

    typedef enum logic [3:0] {
        FN_GET       = 4'd0,
        FN_SET       = 4'd1,
        FN_INS_FRONT = 4'd2,
        FN_INS_BACK  = 4'd3,
        FN_INS_AT    = 4'd4,
        FN_REM_FRONT = 4'd5,
        FN_REM_BACK  = 4'd6,
        FN_REM_AT    = 4'd7,
        FN_CLEAR     = 4'd8
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } dp_op_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_HOLD = 1'b1
    } ctl_state_t;

    // Command from controller to datapath.
    typedef struct packed {
        logic   fire;
        dp_op_t op;
        logic   read_item;
    } dp_cmd_t;

    localparam int FUNC_W   = 4;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

endpackage
`default_nettype wire

// File: rtl/core/positional_list_engine.sv
// Top level of the positional list engine.
`default_nettype none
// Ordered list of up to CAPACITY items held in a chain of registers; every
// cell shifts in parallel, so any request (get, set, insert, remove, clear)
// is applied as it is accepted and a new request is taken every cycle that the
// result register is free or being emptied. One result per request; count
// in the result is the count after that request. Entries beyond count are
// never read. The result is registered and appears the cycle after the request.
module positional_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: func[3:0], position[8:4], value[40:9], zero pad [47:41]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: item_out[31:0], status[33:32], count_out[38:34], zero pad [39]
    output logic [39:0]      m_tdata
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    dp_cmd_t               cmd;
    logic [IDX_W-1:0]      idx;
    logic [CNT_W-1:0]      count;
    logic [ITEM_WIDTH-1:0] item_rd;
    logic [ITEM_WIDTH-1:0] item_in;
    logic [VALUE_W-1:0]    item_out;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    count_out;
    logic [VALUE_W-1:0]    value;

    assign value = s_tdata[40:9];

    generate
        if (ITEM_WIDTH <= VALUE_W)
        begin : g_in_trunc
            assign item_in = value[ITEM_WIDTH-1:0];
        end
        else
        begin : g_in_ext
            assign item_in = {{(ITEM_WIDTH - VALUE_W){1'b0}}, value};
        end
    endgenerate

    ple_control #(
        .CAPACITY(CAPACITY), .ITEM_WIDTH(ITEM_WIDTH), .CNT_W(CNT_W), .IDX_W(IDX_W)
    ) u_ctl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .func(s_tdata[3:0]), .position(s_tdata[8:4]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .idx(idx), .count(count), .item_rd(item_rd),
        .item_out(item_out), .status(status), .count_out(count_out)
    );

    ple_datapath #(
        .CAPACITY(CAPACITY), .ITEM_WIDTH(ITEM_WIDTH), .CNT_W(CNT_W), .IDX_W(IDX_W)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .idx(idx), .item_in(item_in),
        .count(count), .item_rd(item_rd)
    );

    assign m_tdata = {1'b0, count_out, status, item_out};

endmodule
`default_nettype wire

// File: rtl/core/ple_datapath.sv
// Register chain of list cells with parallel shift, plus the count register.
`default_nettype none
module ple_datapath #(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ple_pkg::dp_cmd_t    cmd,
    input  wire logic [IDX_W-1:0]    idx,
    input  wire logic [ITEM_WIDTH-1:0] item_in,
    output logic [CNT_W-1:0]         count,
    output logic [ITEM_WIDTH-1:0]    item_rd
);
    import ple_pkg::*;

    logic [ITEM_WIDTH-1:0] cell_reg [CAPACITY];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign count   = count_reg;
    assign item_rd = cell_reg[idx];

    // Update each cell from itself, a neighbor or the new item
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cmd.fire)
            begin
                unique case (cmd.op)
                    OP_WRITE:
                    begin
                        if (IDX_W'(i) == idx)
                            cell_reg[i] <= item_in;
                    end
                    OP_INSERT:
                    begin
                        if (IDX_W'(i) == idx)
                            cell_reg[i] <= item_in;
                        else if (i > 0 && IDX_W'(i) > idx)
                            cell_reg[i] <= cell_reg[(i > 0) ? i - 1 : 0];
                    end
                    OP_REMOVE:
                    begin
                        if (i < CAPACITY - 1 && IDX_W'(i) >= idx)
                            cell_reg[i] <= cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Track the item count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.fire)
        begin
            unique case (cmd.op)
                OP_INSERT: count_next = count_reg + CNT_W'(1);
                OP_REMOVE: count_next = count_reg - CNT_W'(1);
                OP_CLEAR:  count_next = '0;
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/ple_control.sv
// Request decode, status checks and output register for the list engine.
`default_nettype none
module ple_control #(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [ple_pkg::FUNC_W-1:0] func,
    input  wire logic [ple_pkg::POS_W-1:0]  position,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output ple_pkg::dp_cmd_t             cmd,
    output logic [IDX_W-1:0]             idx,
    input  wire logic [CNT_W-1:0]        count,
    input  wire logic [ITEM_WIDTH-1:0]   item_rd,
    output logic [ple_pkg::VALUE_W-1:0]  item_out,
    output logic [ple_pkg::STATUS_W-1:0] status,
    output logic [ple_pkg::COUNT_W-1:0]  count_out
);
    import ple_pkg::*;

    ctl_state_t state_reg, state_next;
    logic [VALUE_W-1:0]  item_reg;
    logic [STATUS_W-1:0] status_reg;
    status_t             st;
    logic                accept;
    logic                pos_ok;
    logic                full;
    logic                empty;
    logic [CNT_W-1:0]    pos_m1;
    logic [VALUE_W-1:0]  item_ext;

    // Output stage: next request may enter while a result is taken
    assign in_ready  = (state_reg == CS_IDLE) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == CS_HOLD);
    assign item_out  = item_reg;
    assign status    = status_reg;
    assign count_out = COUNT_W'(count);

    assign full   = (count >= CNT_W'(CAPACITY));
    assign empty  = (count == '0);
    assign pos_ok = (position != '0) && ({{(CNT_W + 1){1'b0}}, position} <=
                    (CNT_W + POS_W + 1)'(count));
    assign pos_m1 = CNT_W'(position) - CNT_W'(1);

    generate
        if (ITEM_WIDTH >= VALUE_W)
        begin : g_trunc
            assign item_ext = item_rd[VALUE_W-1:0];
        end
        else
        begin : g_ext
            assign item_ext = {{(VALUE_W - ITEM_WIDTH){1'b0}}, item_rd};
        end
    endgenerate

    // Decode request into a datapath command
    always_comb
    begin
        cmd.fire      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.read_item = 1'b0;
        idx           = '0;
        st            = ST_OK;
        unique case (func)
            FN_GET:
            begin
                idx = IDX_W'(pos_m1);
                if (pos_ok) cmd.read_item = 1'b1;
                else st = ST_BADPOS;
            end
            FN_SET:
            begin
                idx = IDX_W'(pos_m1);
                if (pos_ok) cmd.op = OP_WRITE;
                else st = ST_BADPOS;
            end
            FN_INS_FRONT:
            begin
                if (full) st = ST_FULL;
                else cmd.op = OP_INSERT;
            end
            FN_INS_BACK:
            begin
                idx = IDX_W'(count);
                if (full) st = ST_FULL;
                else cmd.op = OP_INSERT;
            end
            FN_INS_AT:
            begin
                idx = IDX_W'(pos_m1);
                if (full) st = ST_FULL;
                else if (!pos_ok) st = ST_BADPOS;
                else cmd.op = OP_INSERT;
            end
            FN_REM_FRONT:
            begin
                if (empty) st = ST_EMPTY;
                else
                begin
                    cmd.op = OP_REMOVE;
                    cmd.read_item = 1'b1;
                end
            end
            FN_REM_BACK:
            begin
                idx = IDX_W'(count - CNT_W'(1));
                if (empty) st = ST_EMPTY;
                else
                begin
                    cmd.op = OP_REMOVE;
                    cmd.read_item = 1'b1;
                end
            end
            FN_REM_AT:
            begin
                idx = IDX_W'(pos_m1);
                if (empty) st = ST_EMPTY;
                else if (!pos_ok) st = ST_BADPOS;
                else
                begin
                    cmd.op = OP_REMOVE;
                    cmd.read_item = 1'b1;
                end
            end
            FN_CLEAR: cmd.op = OP_CLEAR;
            default:
            begin
            end
        endcase
        cmd.fire = accept;
    end

    // Hold state: a result waits in the output register
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: if (accept) state_next = CS_HOLD;
            CS_HOLD: if (out_ready && !accept) state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture result payload; count is read live from the datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= cmd.read_item ? item_ext : '0;
            status_reg <= st;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none
module ple_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    import ple_pkg::*;

    // Every accepted request yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid) else $error("missing result");

    // Ready whenever no result is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready) else $error("stalled while empty");

    // Non-ok status carries a zero item
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == 32'd0)
        else $error("item on error");

    // Clear leaves an empty list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[3:0] == FN_CLEAR |=> m_tdata[38:34] == 5'd0)
        else $error("clear left items");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed");
endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: bench/positional_list_engine_check.sv
// Checker for the positional list engine: predicts each result and compares it.
`default_nettype none
module positional_list_engine_check
    import ple_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [31:0]      item;
        status_t          status;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    logic [31:0] shadow_items [DEPTH];
    int          shadow_count;
    list_result_t expected_results [$];

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Apply one request to the shadow list and return its result.
    function automatic list_result_t apply_request(input logic [47:0] req);
        func_t       fn;
        int          pos;
        logic [31:0] val;
        list_result_t r;
        fn  = func_t'(req[3:0]);
        pos = int'(req[8:4]);
        val = req[40:9];
        r.item = '0;
        r.status = ST_OK;
        case (fn)
            FN_GET:
                if (pos >= 1 && pos <= shadow_count) r.item = shadow_items[pos-1];
                else r.status = ST_BADPOS;
            FN_SET:
                if (pos >= 1 && pos <= shadow_count) shadow_items[pos-1] = val;
                else r.status = ST_BADPOS;
            FN_INS_FRONT, FN_INS_BACK, FN_INS_AT:
            begin
                int at;
                at = (fn == FN_INS_FRONT) ? 0 : (fn == FN_INS_BACK) ? shadow_count : pos - 1;
                if (shadow_count >= DEPTH) r.status = ST_FULL;
                else if (fn == FN_INS_AT && !(pos >= 1 && pos <= shadow_count))
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = shadow_count; i > at; i--) shadow_items[i] = shadow_items[i-1];
                    shadow_items[at] = val;
                    shadow_count++;
                end
            end
            FN_REM_FRONT, FN_REM_BACK, FN_REM_AT:
            begin
                int at;
                at = (fn == FN_REM_FRONT) ? 0 : (fn == FN_REM_BACK) ? shadow_count - 1 : pos - 1;
                if (shadow_count == 0) r.status = ST_EMPTY;
                else if (fn == FN_REM_AT && !(pos >= 1 && pos <= shadow_count))
                    r.status = ST_BADPOS;
                else
                begin
                    r.item = shadow_items[at];
                    for (int i = at; i + 1 < shadow_count; i++) shadow_items[i] = shadow_items[i+1];
                    shadow_count--;
                end
            end
            FN_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    assign pending = expected_results.size();

    // Predict on every accepted request, compare on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            shadow_count <= 0;
            fail_count   <= 0;
            results_seen <= 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.item)
                        report_mismatch("item_out", m_tdata[31:0], want.item);
                    if (m_tdata[33:32] !== want.status)
                        report_mismatch("status", {30'd0, m_tdata[33:32]},
                                        {30'd0, want.status});
                    if (m_tdata[38:34] !== want.count)
                        report_mismatch("count_out", {27'd0, m_tdata[38:34]},
                                        {27'd0, want.count});
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tdata));
        end
    end

endmodule
`default_nettype wire

// File: bench/positional_list_engine_test.sv
// Top of the positional list engine testbench: stimulus, watchdog and verdict.
`default_nettype none
module positional_list_engine_test;
    import ple_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CALM_ITEMS   = 300;
    localparam int STALL_LIMIT  = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          fail_count, pending, results_seen;
    int          idle_cycles = 0;
    int          requests_sent = 0;
    int          sink_gap = 0;
    bit          sink_calm = 1'b0;
    int          list_len = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positional_list_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    positional_list_engine_check u_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // Track list length roughly so random positions land near the valid range.
    function automatic int next_len(input int len, input logic [3:0] fn, input int pos);
        case (fn)
            FN_INS_FRONT, FN_INS_BACK: return (len < 16) ? len + 1 : len;
            FN_INS_AT: return (len < 16 && pos >= 1 && pos <= len) ? len + 1 : len;
            FN_REM_FRONT, FN_REM_BACK: return (len > 0) ? len - 1 : len;
            FN_REM_AT: return (len > 0 && pos >= 1 && pos <= len) ? len - 1 : len;
            FN_CLEAR: return 0;
            default: return len;
        endcase
    endfunction

    // Present one request and hold it until accepted; valid stays up for the next one.
    task automatic send_request(input logic [3:0] fn, input int pos, input logic [31:0] val,
                                input bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tdata  <= {7'd0, val, pos[4:0], fn};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        requests_sent++;
        list_len = next_len(list_len, fn, pos);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Random sink stalls in bursts, none in the calm tail.
    always @(posedge clk)
    begin
        if (!rst_n || sink_calm)
        begin
            m_tready <= 1'b1;
            sink_gap <= 0;
        end
        else if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= int'($urandom_range(0, 8));
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("positional_list_engine test failed");
            $finish;
        end
    end

    initial
    begin
        logic [3:0]  fn;
        int          pos;
        logic [31:0] val;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list cases, fill to full, overflow, extremes, clear.
        send_request(FN_REM_FRONT, 0, 32'd0, 0);
        send_request(FN_REM_AT, 1, 32'd0, 0);
        send_request(FN_GET, 1, 32'd0, 0);
        send_request(FN_INS_AT, 1, 32'hFFFF_FFFF, 0);
        send_request(FN_INS_BACK, 0, 32'hFFFF_FFFF, 0);
        send_request(FN_INS_AT, 2, 32'h1234_5678, 0);
        for (int i = 0; i < 15; i++)
            send_request(FN_INS_FRONT, 31, 32'(i), 0);
        send_request(FN_INS_AT, 0, 32'hAAAA_AAAA, 0);
        send_request(FN_SET, 16, 32'h5555_5555, 0);
        send_request(FN_GET, 16, 32'd0, 0);
        send_request(FN_GET, 17, 32'd0, 0);
        send_request(FN_REM_AT, 0, 32'd0, 0);
        send_request(FN_REM_BACK, 0, 32'd0, 0);
        send_request(4'd15, 31, 32'hFFFF_FFFF, 0);
        send_request(FN_CLEAR, 0, 32'd0, 0);

        // Random: operations weighted to keep the list moving around its whole range.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            if (n == RANDOM_ITEMS - CALM_ITEMS) sink_calm = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2:    fn = FN_GET;
                3, 4:       fn = FN_SET;
                5, 6:       fn = FN_INS_FRONT;
                7, 8:       fn = FN_INS_BACK;
                9, 10:      fn = FN_INS_AT;
                11:         fn = FN_REM_FRONT;
                12:         fn = FN_REM_BACK;
                13, 14:     fn = FN_REM_AT;
                15:         fn = ($urandom_range(0, 5) == 0) ? FN_CLEAR : FN_GET;
                16:         fn = 4'($urandom_range(9, 15));
                default:    fn = ($urandom_range(0, 1) != 0) ? FN_INS_BACK : FN_REM_BACK;
            endcase
            if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 31);
            else pos = $urandom_range(1, (list_len > 0) ? list_len : 1);
            val = $urandom();
            send_request(fn, pos, val, n < RANDOM_ITEMS - CALM_ITEMS);
        end

        drain_results();
        repeat (5) @(posedge clk);
        $display("Sent %0d requests, checked %0d results; every function code exercised,",
                 requests_sent, results_seen);
        $display("including empty, full and out-of-range positions, with stalls on both sides.");
        if (fail_count == 0)
            $display("positional_list_engine test passed");
        else
            $display("positional_list_engine test failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: positional_list_engine.f
rtl/core/ple_pkg.sv
rtl/core/ple_datapath.sv
rtl/core/ple_control.sv
rtl/core/positional_list_engine.sv
rtl/core/ple_checker.sv
bench/positional_list_engine_check.sv
bench/positional_list_engine_test.sv
